### rtl/wcm_pkg.sv
// Shared types, widths and codes for the wildcard capture matcher.
// Used by wcm_core, wcm_result_fifo and wildcard_capture_matcher_top.
// No dependencies.
package wcm_pkg;

  // Defaults for the top-level parameters
  localparam int PATTERN_MAX_DEF = 8;
  localparam int STR_MAX_DEF     = 4096;

  // Fixed field widths
  localparam int CHAR_W      = 8;
  localparam int PAT_BYTES_W = 64;
  localparam int PAT_LEN_W   = 4;
  localparam int CAP_START_W = 12;
  localparam int CAP_LEN_W   = 13;

  // Wildcard byte in the pattern
  localparam logic [CHAR_W-1:0] STAR_BYTE = 8'h2A;

  // Result kinds
  localparam logic KIND_CAPTURE = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 1'b1;

  // Result queue depth: room for two results per item plus slack
  localparam int RQ_DEPTH = 4;

  typedef struct packed {
    logic [CHAR_W-1:0] char_byte;
    logic              final_byte;
    logic              empty_string;
  } item_t;

  typedef struct packed {
    logic                   kind;
    logic [CAP_START_W-1:0] capture_start;
    logic [CAP_LEN_W-1:0]   capture_length;
    logic                   matched;
    logic                   last_result;
  } res_t;

  function automatic res_t mk_capture(input logic [CAP_START_W-1:0] start,
                                      input logic [CAP_LEN_W-1:0] len);
    res_t r;
    r.kind           = KIND_CAPTURE;
    r.capture_start  = start;
    r.capture_length = len;
    r.matched        = 1'b0;
    r.last_result    = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_verdict(input logic ok);
    res_t r;
    r.kind           = KIND_VERDICT;
    r.capture_start  = '0;
    r.capture_length = '0;
    r.matched        = ok;
    r.last_result    = 1'b1;
    return r;
  endfunction

endpackage

### rtl/wildcard_capture_matcher_top.sv
// Top level of the wildcard capture matcher: ports, configuration registers
// and input register. Depends on wcm_pkg, wcm_core and wcm_result_fifo.
//
// Streams a string one byte per input word against a pattern of up to eight
// bytes in which '*' matches one or more bytes; matching is greedy with no
// backtracking. Each closed capture yields a (start, length) word, and the
// last byte of a string yields a verdict word with last_result set. The block
// takes one byte per cycle while the result queue has room: the word is held
// in an input register, the match step is combinational logic, and results go
// to a four-entry queue that drains one word per cycle while out_stall is low.
// A byte that both closes a capture and ends the string makes two result words,
// which leave the queue one after the other. The first result of a word reaches
// the port after passing the input register and the result queue.
// Write configuration only while no string is in flight; writes are always
// taken (cfg_ready is held high). No clearing pass after reset.
module wildcard_capture_matcher_top import wcm_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int STR_MAX     = STR_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input words
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CHAR_W-1:0]      in_char_byte,
  input  logic                   in_final_byte,
  input  logic                   in_empty_string,
  // result words
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_kind,
  output logic [CAP_START_W-1:0] out_capture_start,
  output logic [CAP_LEN_W-1:0]   out_capture_length,
  output logic                   out_matched,
  output logic                   out_last_result,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [PAT_BYTES_W-1:0] cfg_data
);

  logic [PAT_BYTES_W-1:0] pat_r;
  logic [PAT_LEN_W-1:0]   plen_r;
  logic                   item_v_r;
  item_t                  item_r;
  logic                   room;
  logic                   fire;
  res_t                   res0, res1, out_data;
  logic [1:0]             res_n, push_n;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      plen_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN: pat_r  <= cfg_data;
        REG_LENGTH:  plen_r <= cfg_data[PAT_LEN_W-1:0];
        default:     ;
      endcase
    end
  end

  // Input register: refills whenever it is empty or being processed
  assign fire     = item_v_r && room;
  assign in_stall = item_v_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (!in_stall) begin
      item_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.char_byte    <= in_char_byte;
      item_r.final_byte   <= in_final_byte;
      item_r.empty_string <= in_empty_string;
    end
  end

  wcm_core #(
    .PATTERN_MAX (PATTERN_MAX),
    .STR_MAX     (STR_MAX)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .item           (item_r),
    .pattern_bytes  (pat_r),
    .pattern_length (plen_r),
    .res0           (res0),
    .res1           (res1),
    .res_n          (res_n)
  );

  assign push_n = fire ? res_n : 2'd0;

  wcm_result_fifo u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (res0),
    .push1     (res1),
    .push_n    (push_n),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_kind           = out_data.kind;
  assign out_capture_start  = out_data.capture_start;
  assign out_capture_length = out_data.capture_length;
  assign out_matched        = out_data.matched;
  assign out_last_result    = out_data.last_result;

  // Every end-of-string word produces at least its verdict
  a_final_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item_r.final_byte || item_r.empty_string) |-> push_n != 2'd0)
    else $error("end of string without verdict");

  // A mid-string byte yields at most one capture record
  a_mid_one: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !item_r.final_byte && !item_r.empty_string |-> push_n != 2'd2)
    else $error("two results for a mid-string byte");

  // Only verdicts close a string on the output
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |-> out_kind == KIND_VERDICT)
    else $error("last result is not a verdict");

endmodule

### rtl/wcm_core.sv
// Match state and combinational step logic of the wildcard capture matcher.
// Takes one registered word per fire and produces up to two results.
// Depends on wcm_pkg.
module wcm_core import wcm_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int STR_MAX     = STR_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  item_t                  item,
  input  logic [PAT_BYTES_W-1:0] pattern_bytes,
  input  logic [PAT_LEN_W-1:0]   pattern_length,
  output res_t                   res0,
  output res_t                   res1,
  output logic [1:0]             res_n
);

  localparam int POS_W = $clog2(STR_MAX + 1);

  logic [PAT_LEN_W-1:0]   idx_r, idx_nxt;
  logic                   open_r, open_nxt;
  logic                   absorb_r, absorb_nxt;
  logic [CAP_START_W-1:0] begin_r, begin_nxt;
  logic [POS_W-1:0]       count_r, count_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic                   failed_r, failed_nxt;

  logic [PAT_LEN_W-1:0] plen;
  logic [CHAR_W-1:0]    pc;
  logic                 pos_full;

  // Length above the pattern store size clamps to it
  assign plen = (pattern_length > PAT_LEN_W'(PATTERN_MAX)) ?
                PAT_LEN_W'(PATTERN_MAX) : pattern_length;
  assign pc = pattern_bytes[idx_r[2:0]*CHAR_W +: CHAR_W];
  assign pos_full = (pos_r >= POS_W'(STR_MAX));

  // One step of the greedy matcher
  always_comb begin
    idx_nxt    = idx_r;
    open_nxt   = open_r;
    absorb_nxt = absorb_r;
    begin_nxt  = begin_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    failed_nxt = failed_r;
    res0       = mk_verdict(1'b0);
    res1       = mk_verdict(1'b0);
    res_n      = 2'd0;

    if (item.empty_string) begin
      res0       = mk_verdict(plen == '0);
      res_n      = 2'd1;
      idx_nxt    = '0;
      open_nxt   = 1'b0;
      absorb_nxt = 1'b0;
      begin_nxt  = '0;
      count_nxt  = '0;
      pos_nxt    = '0;
      failed_nxt = 1'b0;
    end else begin
      if (!failed_r) begin
        priority if (pos_full) begin
          failed_nxt = 1'b1;
        end else if (absorb_r) begin
          count_nxt = count_r + POS_W'(1);
        end else if (idx_r >= plen) begin
          // pattern finished: only an open capture can take more bytes
          if (!open_r) begin
            failed_nxt = 1'b1;
          end else begin
            absorb_nxt = 1'b1;
            count_nxt  = count_r + POS_W'(1);
          end
        end else if (pc == STAR_BYTE) begin
          if (!open_r) begin
            open_nxt  = 1'b1;
            begin_nxt = CAP_START_W'(pos_r);
            count_nxt = POS_W'(1);
          end else begin
            count_nxt = count_r + POS_W'(1);
          end
          idx_nxt = idx_r + PAT_LEN_W'(1);
        end else if (item.char_byte == pc) begin
          // literal match closes an open capture
          if (open_r) begin
            res0      = mk_capture(begin_r, CAP_LEN_W'(count_r));
            res_n     = 2'd1;
            open_nxt  = 1'b0;
            count_nxt = '0;
          end
          idx_nxt = idx_r + PAT_LEN_W'(1);
        end else if (open_r) begin
          count_nxt = count_r + POS_W'(1);
        end else begin
          failed_nxt = 1'b1;
        end
      end
      if (!pos_full) begin
        pos_nxt = pos_r + POS_W'(1);
      end

      // End of string: trailing capture, then verdict
      if (item.final_byte) begin
        if (!failed_nxt && idx_nxt < plen) begin
          failed_nxt = 1'b1;
        end
        if (!failed_nxt && open_nxt) begin
          res0  = mk_capture(begin_nxt, CAP_LEN_W'(count_nxt));
          res_n = 2'd1;
        end
        if (res_n == 2'd1) begin
          res1  = mk_verdict(!failed_nxt);
          res_n = 2'd2;
        end else begin
          res0  = mk_verdict(!failed_nxt);
          res_n = 2'd1;
        end
        idx_nxt    = '0;
        open_nxt   = 1'b0;
        absorb_nxt = 1'b0;
        begin_nxt  = '0;
        count_nxt  = '0;
        pos_nxt    = '0;
        failed_nxt = 1'b0;
      end
    end
  end

  // State registers advance once per processed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      open_r   <= 1'b0;
      absorb_r <= 1'b0;
      begin_r  <= '0;
      count_r  <= '0;
      pos_r    <= '0;
      failed_r <= 1'b0;
    end else if (fire) begin
      idx_r    <= idx_nxt;
      open_r   <= open_nxt;
      absorb_r <= absorb_nxt;
      begin_r  <= begin_nxt;
      count_r  <= count_nxt;
      pos_r    <= pos_nxt;
      failed_r <= failed_nxt;
    end
  end

  // Absorbing the tail always implies an open capture
  a_absorb_open: assert property (@(posedge clk) disable iff (!rst_n)
    absorb_r |-> open_r)
    else $error("absorb without open capture");

  // Position saturates at the string limit
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(STR_MAX))
    else $error("string position past limit");

  // When a word yields two results, the capture record comes before the verdict
  a_last_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_n == 2'd2 |-> res0.kind == KIND_CAPTURE && res1.kind == KIND_VERDICT)
    else $error("bad result order");

endmodule

### rtl/wcm_result_fifo.sv
// Small result queue between the match step and the output channel.
// Accepts up to two results per cycle, drains one per cycle while out_stall is low.
// Depends on wcm_pkg.
module wcm_result_fifo import wcm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  res_t       push0,
  input  res_t       push1,
  input  logic [1:0] push_n,
  output logic       room,
  output logic       out_valid,
  input  logic       out_stall,
  output res_t       out_data
);

  localparam int PTR_W = $clog2(RQ_DEPTH);
  localparam int CNT_W = $clog2(RQ_DEPTH + 1);

  res_t             mem_r [RQ_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rp_r];
  assign pop       = out_valid && !out_stall;
  // Room for a two-result word regardless of this cycle's pop
  assign room      = (cnt_r <= CNT_W'(RQ_DEPTH - 2));

  assign wp_nxt  = wp_r + PTR_W'(push_n);
  assign rp_nxt  = rp_r + PTR_W'(pop);
  assign cnt_nxt = cnt_r + CNT_W'(push_n) - CNT_W'(pop);

  // Storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wp_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wp_r + PTR_W'(1)] <= push1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(RQ_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd0 |-> room)
    else $error("push without room");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> wp_r == rp_r)
    else $error("pointers disagree with empty queue");

endmodule
